### rtl/ccm_pkg.sv
// Shared constants, types and codes for the clause co-occurrence matrix.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package ccm_pkg;

  // Sizing of the matrix, the clause buffer and one matrix cell.
  localparam int NUM_VARS   = 256;
  localparam int MAX_CLAUSE = 32;
  localparam int CELL_BITS  = 16;

  // Fixed field widths of the item ports.
  localparam int LIT_BITS   = 9;
  localparam int IDX_BITS   = 8;
  localparam int VALUE_BITS = 16;
  localparam int STAT_BITS  = 2;

  // Derived widths.
  localparam int VAR_BITS      = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int LEN_BITS      = $clog2(MAX_CLAUSE + 1);
  localparam int BUF_ADDR_BITS = (MAX_CLAUSE > 1) ? $clog2(MAX_CLAUSE) : 1;
  localparam int MAT_ADDR_BITS = 2 * VAR_BITS;

  // Q1.15 weight: quotient of 2^15 by the clause length minus one.
  localparam int Q_BITS    = 16;
  localparam int STEP_BITS = $clog2(Q_BITS);

  typedef logic [VAR_BITS-1:0]      var_t;
  typedef logic [LEN_BITS-1:0]      len_t;
  typedef logic [BUF_ADDR_BITS-1:0] buf_addr_t;
  typedef logic [CELL_BITS-1:0]     cell_t;
  typedef logic [MAT_ADDR_BITS-1:0] mat_addr_t;

  localparam cell_t CELL_MAX = '1;

  // Command codes.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result status codes.
  localparam logic [STAT_BITS-1:0] STATUS_READ = 2'd0;
  localparam logic [STAT_BITS-1:0] STATUS_DONE = 2'd1;
  localparam logic [STAT_BITS-1:0] STATUS_OVFL = 2'd2;

  // Write request to the matrix memory.
  typedef struct packed {
    logic      en;
    mat_addr_t addr;
    cell_t     data;
  } mat_wr_t;

  // Write request to the clause buffer.
  typedef struct packed {
    logic      en;
    buf_addr_t addr;
    var_t      data;
  } buf_wr_t;

endpackage
`default_nettype wire

### rtl/ccm_weight_div.sv
// Serial divider that forms the Q1.15 clause weight, one quotient bit a cycle.
// Depends on ccm_pkg.
`default_nettype none
module ccm_weight_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire ccm_pkg::len_t        divisor,
  output logic                      done,
  output ccm_pkg::cell_t            weight
);

  logic                              busy;
  logic [ccm_pkg::STEP_BITS-1:0]     step;
  ccm_pkg::len_t                     rem;
  ccm_pkg::len_t                     dvs;
  logic [ccm_pkg::Q_BITS-1:0]        quo;
  logic [ccm_pkg::LEN_BITS:0]        rem_sh;
  logic                              ge;
  logic                              dbit;

  // The dividend is 2^15: only its top bit is set.
  assign dbit   = (step == ccm_pkg::STEP_BITS'(ccm_pkg::Q_BITS - 1));
  assign rem_sh = {rem, dbit};
  assign ge     = (rem_sh >= {1'b0, dvs});

  // Restoring division, most significant quotient bit first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= ccm_pkg::STEP_BITS'(ccm_pkg::Q_BITS - 1);
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? ccm_pkg::LEN_BITS'(rem_sh - {1'b0, dvs})
                 : ccm_pkg::LEN_BITS'(rem_sh);
      quo  <= {quo[ccm_pkg::Q_BITS-2:0], ge};
      step <= step - 1'b1;
      if (step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Saturate the quotient to the cell range.
  always_comb begin
    if (32'(quo) > 32'(ccm_pkg::CELL_MAX)) begin
      weight = ccm_pkg::CELL_MAX;
    end else begin
      weight = ccm_pkg::CELL_BITS'(quo);
    end
  end

endmodule
`default_nettype wire

### rtl/ccm_clause_buf.sv
// Clause buffer: variable indices of the open clause, one write port and
// two registered read ports. Depends on ccm_pkg.
`default_nettype none
module ccm_clause_buf (
  input  wire logic               clk,
  input  wire ccm_pkg::buf_wr_t   wr,
  input  wire ccm_pkg::buf_addr_t rd_addr_a,
  input  wire ccm_pkg::buf_addr_t rd_addr_b,
  output ccm_pkg::var_t           rd_data_a,
  output ccm_pkg::var_t           rd_data_b
);

  ccm_pkg::var_t mem [ccm_pkg::MAX_CLAUSE];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Two read ports with registered data.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

### rtl/ccm_pair_mem.sv
// Pair matrix storage: one write port and two registered read ports,
// so both symmetric cells of a pair are read in the same cycle. Depends on ccm_pkg.
`default_nettype none
module ccm_pair_mem (
  input  wire logic               clk,
  input  wire ccm_pkg::mat_wr_t   wr,
  input  wire ccm_pkg::mat_addr_t rd_addr_a,
  input  wire ccm_pkg::mat_addr_t rd_addr_b,
  output ccm_pkg::cell_t          rd_data_a,
  output ccm_pkg::cell_t          rd_data_b
);

  ccm_pkg::cell_t mem [2**ccm_pkg::MAT_ADDR_BITS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Two read ports with registered data.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

### rtl/clause_cooccurrence_matrix.sv
// Clause co-occurrence matrix. After reset the block sweeps the matrix
// memory to zero, one cell a cycle (65536 cells at 256 variables), and
// takes no item until the sweep is done; configuration writes are taken at
// any time. A literal item that does not end a clause keeps the block idle.
// A read command passes through the read and emit states and raises its
// result item once the output register is free. A clause end walks all
// len*(len-1)/2 pairs of buffered positions through a read-modify-write of
// the matrix memory in states S_PAIR_RB, S_PAIR_RM, S_PAIR_W1, S_PAIR_W2
// (no S_PAIR_W2 in weighted mode when the cell already holds at least the
// weight), so the single write port of the matrix sets the clause cost; in
// weighted mode a serial division comes first. The result item is held in
// an output register, so literal items keep being taken while it waits.
// Depends on ccm_pkg, ccm_weight_div, ccm_clause_buf, ccm_pair_mem.
`default_nettype none
module clause_cooccurrence_matrix (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration register
  input  wire logic                                 cfg_write_en,
  input  wire logic                                 cfg_write_data,
  // Input items
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 command,
  input  wire logic signed [ccm_pkg::LIT_BITS-1:0]  literal,
  input  wire logic                                 clause_end,
  input  wire logic [ccm_pkg::IDX_BITS-1:0]         read_row,
  input  wire logic [ccm_pkg::IDX_BITS-1:0]         read_col,
  // Result items
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [ccm_pkg::VALUE_BITS-1:0]            entry_value,
  output logic [ccm_pkg::STAT_BITS-1:0]             status
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_DIV,
    S_PAIR_RB,
    S_PAIR_RM,
    S_PAIR_W1,
    S_PAIR_W2,
    S_EMIT
  } state_t;

  state_t                                state;
  logic                                  weighted_mode;
  ccm_pkg::mat_addr_t                    clr_addr;
  ccm_pkg::len_t                         clause_len;
  logic                                  overflow_seen;
  ccm_pkg::len_t                         pair_len;
  ccm_pkg::len_t                         j;
  ccm_pkg::len_t                         k;
  ccm_pkg::var_t                         var_a;
  ccm_pkg::var_t                         var_b;
  ccm_pkg::cell_t                        nv2;
  logic                                  rd_oor;
  logic [ccm_pkg::VALUE_BITS-1:0]        res_value;
  logic [ccm_pkg::STAT_BITS-1:0]         res_status;

  logic [ccm_pkg::LIT_BITS-1:0]          lit_u;
  logic [ccm_pkg::LIT_BITS-1:0]          var_abs;
  logic                                  take;
  ccm_pkg::len_t                         len_after;
  logic                                  ovf_after;
  logic                                  in_fire;
  logic                                  add_fire;
  logic                                  rd_fire;
  logic                                  out_free;
  logic                                  div_start;
  ccm_pkg::cell_t                        weight;
  logic                                  div_done;
  ccm_pkg::buf_wr_t                      buf_wr;
  ccm_pkg::var_t                         buf_rd_a;
  ccm_pkg::var_t                         buf_rd_b;
  ccm_pkg::mat_wr_t                      mat_wr;
  ccm_pkg::mat_addr_t                    mat_rd_addr_a;
  ccm_pkg::mat_addr_t                    mat_rd_addr_b;
  ccm_pkg::cell_t                        mat_rd_a;
  ccm_pkg::cell_t                        mat_rd_b;
  ccm_pkg::cell_t                        nv1;
  ccm_pkg::cell_t                        nv2_count;
  logic                                  w_gt;
  ccm_pkg::len_t                         last_k;
  ccm_pkg::len_t                         last_j;
  logic                                  pairs_done;
  logic [ccm_pkg::VALUE_BITS-1:0]        rd_value;

  // Saturating increment of one cell.
  function automatic ccm_pkg::cell_t cell_inc(input ccm_pkg::cell_t c);
    cell_inc = (c < ccm_pkg::CELL_MAX) ? c + 1'b1 : c;
  endfunction

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      weighted_mode <= 1'b0;
    end else if (cfg_write_en) begin
      weighted_mode <= cfg_write_data;
    end
  end

  // Handshake and literal decoding.
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign add_fire = in_fire && (command == ccm_pkg::CMD_ADD);
  assign rd_fire  = in_fire && (command == ccm_pkg::CMD_READ);
  assign out_free = !out_valid || out_ready;

  // The variable is the magnitude of the two's complement literal.
  assign lit_u     = $unsigned(literal);
  assign var_abs   = lit_u[ccm_pkg::LIT_BITS-1] ? (ccm_pkg::LIT_BITS'(0) - lit_u) : lit_u;
  assign take      = (32'(var_abs) < ccm_pkg::NUM_VARS) &&
                     (32'(clause_len) < ccm_pkg::MAX_CLAUSE);
  assign len_after = clause_len + ccm_pkg::len_t'(take);
  assign ovf_after = overflow_seen || !take;

  // Clause buffer write and pair reads.
  assign buf_wr.en   = add_fire && take;
  assign buf_wr.addr = clause_len[ccm_pkg::BUF_ADDR_BITS-1:0];
  assign buf_wr.data = ccm_pkg::VAR_BITS'(var_abs);

  ccm_clause_buf u_clause_buf (
    .clk       (clk),
    .wr        (buf_wr),
    .rd_addr_a (j[ccm_pkg::BUF_ADDR_BITS-1:0]),
    .rd_addr_b (k[ccm_pkg::BUF_ADDR_BITS-1:0]),
    .rd_data_a (buf_rd_a),
    .rd_data_b (buf_rd_b)
  );

  // Weight divider, started at a long clause end in weighted mode.
  assign div_start = add_fire && clause_end && weighted_mode &&
                     (len_after >= ccm_pkg::len_t'(2));

  ccm_weight_div u_weight_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (len_after - ccm_pkg::len_t'(1)),
    .done    (div_done),
    .weight  (weight)
  );

  // Matrix read addresses: a read command in idle, both symmetric cells of
  // the current pair otherwise.
  always_comb begin
    if (state == S_IDLE) begin
      mat_rd_addr_a = {ccm_pkg::VAR_BITS'(read_row), ccm_pkg::VAR_BITS'(read_col)};
    end else begin
      mat_rd_addr_a = {buf_rd_a, buf_rd_b};
    end
    mat_rd_addr_b = {buf_rd_b, buf_rd_a};
  end

  // New cell values. A pair of equal variables hits the diagonal twice.
  assign nv1       = cell_inc(mat_rd_a);
  assign nv2_count = (var_a == var_b) ? cell_inc(nv1) : cell_inc(mat_rd_b);
  assign w_gt      = (weight > mat_rd_a);

  // Matrix write port.
  always_comb begin
    mat_wr.en   = 1'b0;
    mat_wr.addr = {var_a, var_b};
    mat_wr.data = nv1;
    case (state)
      S_CLEAR: begin
        mat_wr.en   = 1'b1;
        mat_wr.addr = clr_addr;
        mat_wr.data = '0;
      end
      S_PAIR_W1: begin
        mat_wr.en   = !weighted_mode || w_gt;
        mat_wr.data = weighted_mode ? weight : nv1;
      end
      S_PAIR_W2: begin
        mat_wr.en   = 1'b1;
        mat_wr.addr = {var_b, var_a};
        mat_wr.data = nv2;
      end
      default: begin
        mat_wr.en = 1'b0;
      end
    endcase
  end

  ccm_pair_mem u_pair_mem (
    .clk       (clk),
    .wr        (mat_wr),
    .rd_addr_a (mat_rd_addr_a),
    .rd_addr_b (mat_rd_addr_b),
    .rd_data_a (mat_rd_a),
    .rd_data_b (mat_rd_b)
  );

  // Pair walk bounds.
  assign last_k     = pair_len - ccm_pkg::len_t'(1);
  assign last_j     = pair_len - ccm_pkg::len_t'(2);
  assign pairs_done = (k == last_k) && (j == last_j);

  // Read data saturated to the result width.
  assign rd_value = (32'(mat_rd_a) > 32'(16'hFFFF)) ? '1 : ccm_pkg::VALUE_BITS'(mat_rd_a);

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      clause_len    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // In the emit state the outgoing item is replaced there instead.
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (rd_fire) begin
            rd_oor <= (32'(read_row) >= ccm_pkg::NUM_VARS) ||
                      (32'(read_col) >= ccm_pkg::NUM_VARS);
            state  <= S_RD;
          end else if (add_fire) begin
            if (clause_end) begin
              clause_len    <= '0;
              overflow_seen <= 1'b0;
              pair_len      <= len_after;
              j             <= '0;
              k             <= ccm_pkg::len_t'(1);
              res_value     <= '0;
              res_status    <= ovf_after ? ccm_pkg::STATUS_OVFL : ccm_pkg::STATUS_DONE;
              if (len_after < ccm_pkg::len_t'(2)) begin
                state <= S_EMIT;
              end else if (weighted_mode) begin
                state <= S_DIV;
              end else begin
                state <= S_PAIR_RB;
              end
            end else begin
              clause_len    <= len_after;
              overflow_seen <= ovf_after;
            end
          end
        end
        S_RD: begin
          res_value  <= rd_oor ? '0 : rd_value;
          res_status <= ccm_pkg::STATUS_READ;
          state      <= S_EMIT;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_PAIR_RB;
          end
        end
        S_PAIR_RB: begin
          state <= S_PAIR_RM;
        end
        S_PAIR_RM: begin
          var_a <= buf_rd_a;
          var_b <= buf_rd_b;
          state <= S_PAIR_W1;
        end
        S_PAIR_W1: begin
          if (!weighted_mode || w_gt) begin
            nv2   <= weighted_mode ? weight : nv2_count;
            state <= S_PAIR_W2;
          end else if (pairs_done) begin
            state <= S_EMIT;
          end else begin
            state <= S_PAIR_RB;
            if (k == last_k) begin
              j <= j + 1'b1;
              k <= j + ccm_pkg::len_t'(2);
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_PAIR_W2: begin
          if (pairs_done) begin
            state <= S_EMIT;
          end else begin
            state <= S_PAIR_RB;
            if (k == last_k) begin
              j <= j + 1'b1;
              k <= j + ccm_pkg::len_t'(2);
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            entry_value <= res_value;
            status      <= res_status;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the clause co-occurrence matrix block.
// It holds its own shadow matrix and clause buffer to predict every result;
// depends on ccm_pkg and clause_cooccurrence_matrix.
`timescale 1ns / 100ps

module testbench;

  // Run control.
  localparam int WATCHDOG_LIMIT = 200_000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 100;
  localparam int RANDOM_PHASES  = 6;
  localparam int MAX_REPORTS    = 10;
  localparam int VAR_POOL_TOP   = 15;
  localparam int DIAG_CLAUSES   = 4;
  localparam int unsigned Q15_ONE = 32768;

  // One result item as the block returns it.
  typedef struct packed {
    logic [ccm_pkg::VALUE_BITS-1:0] value;
    logic [ccm_pkg::STAT_BITS-1:0]  stat;
  } reply_t;

  logic                                 clk;
  logic                                 rst;
  logic                                 cfg_write_en;
  logic                                 cfg_write_data;
  logic                                 in_valid;
  logic                                 in_ready;
  logic                                 command;
  logic signed [ccm_pkg::LIT_BITS-1:0]  literal;
  logic                                 clause_end;
  logic [ccm_pkg::IDX_BITS-1:0]         read_row;
  logic [ccm_pkg::IDX_BITS-1:0]         read_col;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [ccm_pkg::VALUE_BITS-1:0]       entry_value;
  logic [ccm_pkg::STAT_BITS-1:0]        status;

  clause_cooccurrence_matrix u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .literal        (literal),
    .clause_end     (clause_end),
    .read_row       (read_row),
    .read_col       (read_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .entry_value    (entry_value),
    .status         (status)
  );

  // Shadow copy of the block state.
  ccm_pkg::cell_t shadow_cells [0:ccm_pkg::NUM_VARS*ccm_pkg::NUM_VARS-1];
  ccm_pkg::var_t  shadow_clause [0:ccm_pkg::MAX_CLAUSE-1];
  int             shadow_len;
  bit             shadow_ovfl;
  bit             shadow_weighted;

  reply_t replies_due [$];
  reply_t oldest_reply;
  int     mismatch_count;
  int     in_gap_max;
  int     out_stall_max;
  int     rsp_stall_left;
  int     quiet_cycles;
  int     items_sent;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic void bump_shadow_cell(input int idx);
    if (shadow_cells[idx] < ccm_pkg::CELL_MAX) begin
      shadow_cells[idx] = shadow_cells[idx] + 1'b1;
    end
  endfunction

  // Walk every pair of buffered positions and update both symmetric cells.
  function automatic void close_shadow_clause();
    int unsigned weight;
    int ab;
    int ba;
    if (shadow_len < 2) begin
      return;
    end
    weight = Q15_ONE / (shadow_len - 1);
    if (weight > ccm_pkg::CELL_MAX) begin
      weight = ccm_pkg::CELL_MAX;
    end
    for (int j = 0; j + 1 < shadow_len; j++) begin
      for (int k = j + 1; k < shadow_len; k++) begin
        ab = shadow_clause[j] * ccm_pkg::NUM_VARS + shadow_clause[k];
        ba = shadow_clause[k] * ccm_pkg::NUM_VARS + shadow_clause[j];
        if (shadow_weighted) begin
          if (weight > shadow_cells[ab]) begin
            shadow_cells[ab] = ccm_pkg::cell_t'(weight);
            shadow_cells[ba] = ccm_pkg::cell_t'(weight);
          end
        end else begin
          bump_shadow_cell(ab);
          bump_shadow_cell(ba);
        end
      end
    end
  endfunction

  // Apply one accepted item to the shadow state and queue any result it causes.
  function automatic void predict_matrix_item(input logic cmd,
                                              input logic [ccm_pkg::LIT_BITS-1:0] lit,
                                              input logic last,
                                              input logic [ccm_pkg::IDX_BITS-1:0] row,
                                              input logic [ccm_pkg::IDX_BITS-1:0] col);
    int unsigned mag;
    reply_t r;
    if (cmd == ccm_pkg::CMD_READ) begin
      r.value = '0;
      if (row < ccm_pkg::NUM_VARS && col < ccm_pkg::NUM_VARS) begin
        r.value = shadow_cells[row * ccm_pkg::NUM_VARS + col];
      end
      r.stat = ccm_pkg::STATUS_READ;
      replies_due.push_back(r);
      return;
    end
    mag = lit[ccm_pkg::LIT_BITS-1] ? (512 - lit) : lit;
    if (mag >= ccm_pkg::NUM_VARS || shadow_len >= ccm_pkg::MAX_CLAUSE) begin
      shadow_ovfl = 1'b1;
    end else begin
      shadow_clause[shadow_len] = ccm_pkg::var_t'(mag);
      shadow_len++;
    end
    if (last) begin
      close_shadow_clause();
      r.value = '0;
      r.stat  = shadow_ovfl ? ccm_pkg::STATUS_OVFL : ccm_pkg::STATUS_DONE;
      replies_due.push_back(r);
      shadow_len  = 0;
      shadow_ovfl = 1'b0;
    end
  endfunction

  // Predict on every accepted input item.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_matrix_item(command, literal, clause_end, read_row, read_col);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result: entry_value=%0d status=%0d",
                                entry_value, status));
      end else begin
        oldest_reply = replies_due.pop_front();
        if (entry_value !== oldest_reply.value) begin
          note_mismatch($sformatf("entry_value: expected %0d, got %0d",
                                  oldest_reply.value, entry_value));
        end
        if (status !== oldest_reply.stat) begin
          note_mismatch($sformatf("status: expected %0d, got %0d",
                                  oldest_reply.stat, status));
        end
      end
      rsp_stall_left = $urandom_range(0, out_stall_max);
    end
  end

  // Result side backpressure.
  always @(negedge clk) begin
    if (rsp_stall_left > 0) begin
      out_ready <= 1'b0;
      rsp_stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles where no item moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Present one item after a random gap and hold it until it is taken.
  task automatic send_item(input logic cmd, input logic [ccm_pkg::LIT_BITS-1:0] lit,
                           input logic last, input logic [ccm_pkg::IDX_BITS-1:0] row,
                           input logic [ccm_pkg::IDX_BITS-1:0] col);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    literal    <= lit;
    clause_end <= last;
    read_row   <= row;
    read_col   <= col;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_literal(input int lit, input bit last);
    send_item(ccm_pkg::CMD_ADD, lit[ccm_pkg::LIT_BITS-1:0], last,
              ccm_pkg::IDX_BITS'($urandom_range(0, 255)),
              ccm_pkg::IDX_BITS'($urandom_range(0, 255)));
  endtask

  task automatic send_read(input int row, input int col);
    send_item(ccm_pkg::CMD_READ, ccm_pkg::LIT_BITS'($urandom_range(0, 511)),
              1'($urandom_range(0, 1)), ccm_pkg::IDX_BITS'(row), ccm_pkg::IDX_BITS'(col));
  endtask

  // Stop sending, wait for every prediction to be met, then let the block settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input bit weighted);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= weighted;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    shadow_weighted = weighted;
  endtask

  // Count mode: duplicates, extreme variables, short clause, read inside a
  // clause and a variable beyond the matrix.
  task automatic test_count_pairs();
    write_mode(1'b0);
    send_literal(3, 1'b0);
    send_literal(-3, 1'b1);
    send_literal(255, 1'b0);
    send_literal(-255, 1'b0);
    send_literal(0, 1'b1);
    send_literal(7, 1'b1);
    send_literal(-1, 1'b0);
    send_read(3, 3);
    send_literal(2, 1'b1);
    send_literal(5, 1'b0);
    send_literal(-ccm_pkg::NUM_VARS, 1'b0);
    send_literal(6, 1'b1);
    send_read(3, 3);
    send_read(255, 0);
    send_read(0, 255);
    send_read(255, 255);
    send_read(2, 1);
    send_read(5, 6);
    send_read(0, 0);
    send_read(7, 7);
    wait_idle();
  endtask

  // Weighted mode keeps the largest reciprocal weight; old counts survive.
  task automatic test_weighted_max();
    write_mode(1'b1);
    send_literal(20, 1'b0);
    send_literal(21, 1'b1);
    send_literal(20, 1'b0);
    send_literal(-21, 1'b0);
    send_literal(22, 1'b1);
    send_literal(4, 1'b0);
    send_literal(-4, 1'b1);
    send_read(21, 20);
    send_read(20, 22);
    send_read(22, 21);
    send_read(4, 4);
    send_read(3, 3);
    wait_idle();
  endtask

  // Literals past a full buffer are dropped; a clause of exactly full length is not.
  task automatic test_full_buffer();
    for (int i = 0; i < ccm_pkg::MAX_CLAUSE + 2; i++) begin
      send_literal((i % 2) ? -(100 + i) : (100 + i), i == ccm_pkg::MAX_CLAUSE + 1);
    end
    send_read(100, 131);
    send_read(131, 100);
    send_read(100, 132);
    wait_idle();
    write_mode(1'b0);
    for (int i = 0; i < ccm_pkg::MAX_CLAUSE; i++) begin
      send_literal(140 + i, i == ccm_pkg::MAX_CLAUSE - 1);
    end
    send_read(140, 171);
    send_read(171, 171);
    wait_idle();
  endtask

  // Pile count increments onto one diagonal cell that starts from a weight.
  task automatic test_diagonal_load();
    write_mode(1'b1);
    send_literal(50, 1'b0);
    send_literal(-50, 1'b1);
    wait_idle();
    write_mode(1'b0);
    for (int c = 0; c < DIAG_CLAUSES; c++) begin
      for (int i = 0; i < ccm_pkg::MAX_CLAUSE; i++) begin
        send_literal($urandom_range(0, 1) ? 50 : -50, i == ccm_pkg::MAX_CLAUSE - 1);
      end
      if (c % 2 == 1) begin
        send_read(50, 50);
      end
    end
    send_read(50, 50);
    wait_idle();
  endtask

  // Mostly small variables so that reads hit cells that were written.
  function automatic int pick_literal();
    int roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      return -ccm_pkg::NUM_VARS;
    end
    v = (roll < 78) ? $urandom_range(0, VAR_POOL_TOP)
                    : $urandom_range(0, ccm_pkg::NUM_VARS - 1);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic random_read();
    if ($urandom_range(0, 99) < 70) begin
      send_read($urandom_range(0, VAR_POOL_TOP), $urandom_range(0, VAR_POOL_TOP));
    end else begin
      send_read($urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  task automatic random_clause();
    int roll;
    int len;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      len = $urandom_range(1, 6);
    end else if (roll < 90) begin
      len = $urandom_range(7, ccm_pkg::MAX_CLAUSE);
    end else begin
      len = $urandom_range(ccm_pkg::MAX_CLAUSE + 1, ccm_pkg::MAX_CLAUSE + 4);
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 10) begin
        random_read();
      end
      send_literal(pick_literal(), i == len - 1);
    end
  endtask

  // Random clauses and reads in phases with varying mode and pacing.
  task automatic test_random_traffic();
    int phase_end;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_mode((p < 2) ? p[0] : 1'($urandom_range(0, 1)));
      in_gap_max    = (p == 2 || p == 4) ? 0 : 10;
      out_stall_max = (p == 3 || p == 4) ? 0 : 10;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 80) begin
          random_clause();
        end else begin
          random_read();
        end
      end
      wait_idle();
    end
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = 1'b0;
    in_valid       = 1'b0;
    command        = ccm_pkg::CMD_ADD;
    literal        = '0;
    clause_end     = 1'b0;
    read_row       = '0;
    read_col       = '0;
    out_ready      = 1'b0;
    rsp_stall_left = 0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    items_sent     = 0;
    in_gap_max     = 10;
    out_stall_max  = 10;
    for (int i = 0; i < ccm_pkg::NUM_VARS * ccm_pkg::NUM_VARS; i++) begin
      shadow_cells[i] = '0;
    end
    shadow_len      = 0;
    shadow_ovfl     = 1'b0;
    shadow_weighted = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_count_pairs();
    test_weighted_max();
    test_full_buffer();
    test_diagonal_load();
    test_random_traffic();

    wait_idle();
    while (replies_due.size() > 0) begin
      oldest_reply = replies_due.pop_front();
      note_mismatch($sformatf("missing result: entry_value=%0d status=%0d",
                              oldest_reply.value, oldest_reply.stat));
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
